>>> hw/rtl/cqs_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the circular queue with search.
// Holds operation and status codes, field widths and default sizes; no dependencies.
package cqs_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 3;
  localparam int COUNT_W  = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

endpackage

>>> hw/rtl/cqs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; no reset on the storage.
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/circular_queue_with_search_unit.sv
`timescale 1ns / 1ps
// Top level of the circular queue with search: control, pointers and output register.
// Depends on cqs_pkg and cqs_ram (entry storage).
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_operation, in_value | to block
//  out     | out_valid, out_ready, out_status,          | from block
//          | out_data_out, out_match_offset,            |
//          | out_match_count, out_occupancy             |
//
// One item is in work at a time; in_ready is high only when the control is idle.
// Insert, the unused code and an underflowing delete go straight to the finish; delete reads the RAM,
// and search streams every occupied entry (none when empty): one entry is streamed per cycle.
// Results go to an output register, so the next item can be taken while a result waits.
// A finished item waits in its final state until the output register is free.
// Synchronous active-low reset empties the queue; entry storage is not cleared.
module circular_queue_with_search_unit
  #(
  parameter int DEPTH      = cqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cqs_pkg::OP_W-1:0]           in_operation,
  input  logic signed [cqs_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cqs_pkg::STATUS_W-1:0]       out_status,
  output logic signed [cqs_pkg::VALUE_W-1:0] out_data_out,
  output logic [cqs_pkg::OFFSET_W-1:0]       out_match_offset,
  output logic [cqs_pkg::COUNT_W-1:0]        out_match_count,
  output logic [cqs_pkg::COUNT_W-1:0]        out_occupancy
);
  import cqs_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  // Control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      iss_k_r, iss_k_nxt;
  logic                  cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]      cmp_k_r, cmp_k_nxt;
  logic [CNT_W-1:0]      hit_cnt_r, hit_cnt_nxt;
  logic [IDX_W-1:0]      hit_off_r, hit_off_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [DATA_WIDTH-1:0] res_data_r, res_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VALUE_W-1:0]    out_data_r;
  logic [OFFSET_W-1:0]   out_off_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic [COUNT_W-1:0]    out_occ_r;

  logic                  ram_we;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [DATA_WIDTH-1:0] in_word;
  logic                  accept;
  logic                  out_load;
  logic                  q_full;
  logic                  q_empty;

  assign in_word  = DATA_WIDTH'(in_value);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign q_full   = (count_r == CNT_FULL);
  assign q_empty  = (count_r == '0);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign ram_we   = accept && (in_operation == OP_INSERT) && !q_full;

  cqs_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata(in_word),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequence one item: update pointers, stream the store for a search, then finish
  always_comb begin
    logic hit;
    hit            = cmp_valid_r && (ram_rdata == word_r);
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    word_nxt       = word_r;
    ptr_nxt        = ptr_r;
    iss_k_nxt      = iss_k_r;
    cmp_valid_nxt  = 1'b0;
    cmp_k_nxt      = cmp_k_r;
    hit_cnt_nxt    = hit_cnt_r;
    hit_off_nxt    = hit_off_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = STAT_DONE;
          res_data_nxt   = '0;
          hit_cnt_nxt    = '0;
          hit_off_nxt    = '0;
          word_nxt       = in_word;
          ptr_nxt        = head_r;
          iss_k_nxt      = '0;
          state_nxt      = S_FIN;
          case (in_operation)
            OP_INSERT: begin
              if (q_full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                tail_nxt  = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DELETE: begin
              if (q_empty) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                head_nxt  = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
                state_nxt = S_DEL;
              end
            end
            OP_SEARCH: begin
              if (q_empty) begin
                res_status_nxt = STAT_NOTFOUND;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            default: begin
              // unused code: report done, change nothing
            end
          endcase
        end
      end
      S_DEL: begin
        res_data_nxt = ram_rdata;
        state_nxt    = S_FIN;
      end
      S_SRCH: begin
        // issue one read per cycle until every occupied entry is fetched
        if (iss_k_r < count_r) begin
          ram_re        = 1'b1;
          ram_raddr     = ptr_r;
          ptr_nxt       = (ptr_r == IDX_LAST) ? '0 : ptr_r + 1'b1;
          iss_k_nxt     = iss_k_r + 1'b1;
          cmp_valid_nxt = 1'b1;
          cmp_k_nxt     = iss_k_r[IDX_W-1:0];
        end
        // compare the entry fetched last cycle
        if (hit) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
          if (hit_cnt_r == '0) begin
            hit_off_nxt = cmp_k_r;
          end
        end
        if (cmp_valid_r && (CNT_W'(cmp_k_r) == count_r - CNT_ONE)) begin
          res_status_nxt = (hit_cnt_nxt != '0) ? STAT_DONE : STAT_NOTFOUND;
          cmp_valid_nxt  = 1'b0;
          state_nxt      = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load a finished item, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    ptr_r        <= ptr_nxt;
    iss_k_r      <= iss_k_nxt;
    cmp_k_r      <= cmp_k_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    hit_off_r    <= hit_off_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= VALUE_W'(res_data_r);
      out_off_r    <= OFFSET_W'(hit_off_r);
      out_cnt_r    <= COUNT_W'(hit_cnt_r);
      out_occ_r    <= COUNT_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data_out     = out_data_r;
  assign out_match_offset = out_off_r;
  assign out_match_count  = out_cnt_r;
  assign out_occupancy    = out_occ_r;

  // Empty or full queue has head and tail on the same entry
  a_ptr_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (q_empty || q_full) |-> (head_r == tail_r))
    else $error("head and tail disagree at empty or full");

  // Insert into a queue with room grows occupancy by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_INSERT) && !q_full) |=>
      (count_r == $past(count_r) + CNT_ONE))
    else $error("insert did not grow the queue");

  // Only one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("item taken while another is in work");

  // Compared entry always lies inside the occupied range
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_valid_r |-> (CNT_W'(cmp_k_r) < count_r))
    else $error("search compared an unoccupied entry");

endmodule

>>> test/circular_queue_with_search_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the circular queue with search: predicts each result and compares it.
// Depends on cqs_pkg; watches both channels of circular_queue_with_search_unit.
module circular_queue_with_search_unit_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [cqs_pkg::OP_W-1:0]            in_operation,
  input  logic signed [cqs_pkg::VALUE_W-1:0]  in_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [cqs_pkg::STATUS_W-1:0]        out_status,
  input  logic signed [cqs_pkg::VALUE_W-1:0]  out_data_out,
  input  logic [cqs_pkg::OFFSET_W-1:0]        out_match_offset,
  input  logic [cqs_pkg::COUNT_W-1:0]         out_match_count,
  input  logic [cqs_pkg::COUNT_W-1:0]         out_occupancy,
  output int                                  mismatches,
  output int                                  results_pending
);
  import cqs_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W-1:0]  occupancy;
  } queue_result_t;

  // Shadow copy of the queue
  logic [VALUE_W-1:0] shadow_entries [QDEPTH];
  int                 shadow_head;
  int                 shadow_tail;
  int                 shadow_fill;

  queue_result_t op_results_due [$];

  initial begin
    mismatches      = 0;
    results_pending = 0;
    shadow_head     = 0;
    shadow_tail     = 0;
    shadow_fill     = 0;
  end

  // Apply one operation to the shadow queue and return the result it should produce
  function automatic queue_result_t apply_queue_op(logic [OP_W-1:0] op,
                                                   logic [VALUE_W-1:0] word);
    queue_result_t r;
    int            pos;
    bit            found;
    r     = '0;
    found = 1'b0;
    case (op)
      OP_INSERT: begin
        if (shadow_fill >= QDEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_tail] = word;
          shadow_tail = (shadow_tail + 1) % QDEPTH;
          shadow_fill++;
          r.status = STAT_DONE;
        end
      end
      OP_DELETE: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data = shadow_entries[shadow_head];
          shadow_head = (shadow_head + 1) % QDEPTH;
          shadow_fill--;
          r.status = STAT_DONE;
        end
      end
      OP_SEARCH: begin
        // Walk head to tail, following wrap-around
        for (int k = 0; k < shadow_fill; k++) begin
          pos = (shadow_head + k) % QDEPTH;
          if (shadow_entries[pos] == word) begin
            if (!found) begin
              r.offset = k[OFFSET_W-1:0];
              found    = 1'b1;
            end
            r.count = r.count + 1'b1;
          end
        end
        r.status = found ? STAT_DONE : STAT_NOTFOUND;
      end
      default: r.status = STAT_DONE;
    endcase
    r.occupancy = shadow_fill[COUNT_W-1:0];
    return r;
  endfunction

  // Compare accepted results, then predict from accepted items
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    if (!rst_n) begin
      shadow_head = 0;
      shadow_tail = 0;
      shadow_fill = 0;
      op_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_status, out_data_out, out_match_offset, out_match_count, out_occupancy};
        if (op_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result status=%0d data=%h off=%0d cnt=%0d occ=%0d",
                     $realtime, got.status, got.data, got.offset, got.count,
                     got.occupancy);
        end else begin
          want = op_results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: expected status=%0d data=%h off=%0d ",
                        "cnt=%0d occ=%0d, got status=%0d data=%h off=%0d cnt=%0d occ=%0d"},
                       $realtime, want.status, want.data, want.offset, want.count,
                       want.occupancy, got.status, got.data, got.offset, got.count,
                       got.occupancy);
          end
        end
      end
      if (in_valid && in_ready)
        op_results_due.push_back(apply_queue_op(in_operation, in_value));
    end
    results_pending = op_results_due.size();
  end

endmodule

>>> test/circular_queue_with_search_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for circular_queue_with_search_unit: clock, reset, stimulus and verdict.
// Depends on cqs_pkg, the block itself and circular_queue_with_search_unit_checker.
module circular_queue_with_search_unit_tb;
  import cqs_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 30;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [OP_W-1:0]           in_operation;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_data_out;
  logic [OFFSET_W-1:0]       out_match_offset;
  logic [COUNT_W-1:0]        out_match_count;
  logic [COUNT_W-1:0]        out_occupancy;

  int                 mismatches;
  int                 results_pending;
  int                 idle_cycles;
  bit                 no_gaps;
  logic [VALUE_W-1:0] value_pool [4];

  circular_queue_with_search_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_data_out     (out_data_out),
    .out_match_offset (out_match_offset),
    .out_match_count  (out_match_count),
    .out_occupancy    (out_occupancy)
  );

  circular_queue_with_search_unit_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_data_out     (out_data_out),
    .out_match_offset (out_match_offset),
    .out_match_count  (out_match_count),
    .out_occupancy    (out_occupancy),
    .mismatches       (mismatches),
    .results_pending  (results_pending)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: end the run after too many cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles before taking each item
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= word;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Draw a word: half from recent values so searches hit, some fresh, some extremes
  function automatic logic [VALUE_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return value_pool[$urandom_range(0, 3)];
    if (roll < 60) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // Draw an operation, leaning toward filling or draining by phase
  function automatic logic [OP_W-1:0] pick_op(input int lean);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return OP_NONE;
    case (lean)
      0:       return (roll < 60) ? OP_INSERT : (roll < 75) ? OP_DELETE : OP_SEARCH;
      1:       return (roll < 20) ? OP_INSERT : (roll < 65) ? OP_DELETE : OP_SEARCH;
      default: return (roll < 40) ? OP_INSERT : (roll < 70) ? OP_DELETE : OP_SEARCH;
    endcase
  endfunction

  // Stimulus and verdict
  initial begin
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] word;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_INSERT;
    in_value     = '0;
    no_gaps      = 1'b0;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue: search, delete underflow, unused code
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_DELETE, 32'h0000_0000);
    send_item(OP_NONE,   32'h7FFF_FFFF);
    // Fill with extremes and a duplicate
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0001);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_INSERT, 32'hAAAA_AAAA);
    // Full: overflow, then searches for head, duplicate, tail and a missing word
    send_item(OP_INSERT, 32'h0000_007B);
    send_item(OP_SEARCH, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 32'h8000_0000);
    send_item(OP_SEARCH, 32'hAAAA_AAAA);
    send_item(OP_SEARCH, 32'h0000_0002);
    send_item(OP_NONE,   32'h0000_0000);
    // Drain a few and wrap the tail, then search across the wrap
    send_item(OP_DELETE, 32'hFFFF_FFFF);
    send_item(OP_DELETE, 32'h0000_0000);
    send_item(OP_DELETE, 32'h1234_5678);
    send_item(OP_INSERT, 32'h0000_C0DE);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 32'h7FFF_FFFF);

    // Random phases: fill-leaning, drain-leaning, balanced; some with no gaps
    for (int phase = 0; phase < 12; phase++) begin
      no_gaps = (phase % 4 == 3);
      for (int n = 0; n < 50; n++) begin
        op   = pick_op(phase % 3);
        word = (op == OP_DELETE) ? VALUE_W'($urandom) : pick_word();
        if (op == OP_INSERT && $urandom_range(0, 3) == 0)
          value_pool[$urandom_range(0, 3)] = word;
        send_item(op, word);
      end
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
